### rtl/ser_pkg.sv
package ser_pkg;

   // fixed-point widths
   localparam int unsigned VolW   = 32;
   localparam int unsigned FracW  = 17;
   localparam int unsigned ExpW   = 20;
   localparam int unsigned FloorW = 16;
   localparam int unsigned SatW   = 31;   // Q1.30, max 2^30
   localparam int unsigned LogFb  = 20;   // log fraction bits
   localparam int unsigned LogW   = 25;   // -log2(s) in Q.20, up to 30*2^20
   localparam int unsigned QuoW   = 62;   // stored << 30
   localparam int unsigned DivStages = 31; // quotient bits below 2^31

   localparam logic [SatW-1:0] OneQ30 = SatW'(1) << 30;

   // integer square root of a 64-bit value, truncated
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] bit_v;
      res   = '0;
      rem   = x;
      bit_v = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^-(2^-i) in Q0.32, i = 1..20, each the square root of the one before
   function automatic logic [32:0] exp_const(input int unsigned i);
      logic [63:0] c;
      c = 64'd1 << 31;
      for (int unsigned k = 1; k <= LogFb; k++) begin
         if (k <= i) c = isqrt64(c << 32);
      end
      return c[32:0];
   endfunction

endpackage

### rtl/soil_exfiltration_rate_top.sv
// soil exfiltration rate kernel
//
// req_ channel: pulse req_start with the six cell fields while req_busy is low.
// req_busy is tied low; a new cell may be issued every clock.
// csr_ channel: write the capacity floor with csr_valid/csr_ready; csr_ready is
// always high. write it only while no cell is in flight.
// rsp_ channel: one word per cell, marked by rsp_strobe for one cycle.
// the receiver cannot stall, so no backpressure exists.
// pipeline: a cell passes the input register, 31 restoring divider stages,
// saturation cap, normalize, 20 log squaring stages, exponent product, power
// seed, 20 power multiply stages, coefficient and moisture products, output
// register. throughput: one cell per clock.
// every loop is unrolled into registered stages; at most two multipliers of
// about 32x32 sit in one stage.
// reset: synchronous, clears the floor and all valid bits; payload registers
// are not reset.
module soil_exfiltration_rate_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_start,
   output logic                        req_busy,
   input  logic [ser_pkg::VolW-1:0]    req_water_stored,
   input  logic [ser_pkg::VolW-1:0]    req_storage_limit,
   input  logic [ser_pkg::FracW-1:0]   req_wilting_fraction,
   input  logic [ser_pkg::FracW-1:0]   req_mean_porosity,
   input  logic [ser_pkg::VolW-1:0]    req_rate_coefficient,
   input  logic [ser_pkg::ExpW-1:0]    req_saturation_exponent,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ser_pkg::FloorW-1:0]  csr_capacity_floor,
   output logic                        rsp_strobe,
   output logic [ser_pkg::VolW-1:0]    rsp_exfiltration_rate,
   output logic                        rsp_no_capacity,
   output logic                        rsp_moisture_limited
);
   import ser_pkg::*;

   localparam int unsigned D0 = DivStages;  // divider
   localparam int unsigned L0 = LogFb;      // log squaring

   // side data carried with each cell
   typedef struct packed {
      logic [VolW-1:0]  coef;
      logic [ExpW-1:0]  expo;
      logic [FracW-1:0] wilt;
      logic [FracW-1:0] por;
      logic             nocap;
   } side_type;

   logic [FloorW-1:0] floor_ff;
   assign csr_ready = 1'b1;
   assign req_busy  = 1'b0;

   // floor register
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
      end else if (csr_valid) begin
         floor_ff <= csr_capacity_floor;
      end
   end

   // ---------------- divider: s = (stored<<30)/cap, one quotient bit a stage
   logic                 dv_ff  [0:D0];
   side_type             dsd_ff [0:D0];
   logic [QuoW-1:0]      dnum_ff[0:D0];
   logic [VolW:0]        drem_ff[0:D0];
   logic [VolW-1:0]      dcap_ff[0:D0];
   logic [SatW-1:0]      dq_ff  [0:D0];

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else       dv_ff[0] <= req_start;
      dsd_ff[0]  <= '{coef: req_rate_coefficient, expo: req_saturation_exponent,
                      wilt: req_wilting_fraction, por: req_mean_porosity,
                      nocap: (req_storage_limit <= VolW'(floor_ff))};
      // quotient fits in 31 bits whenever stored < 2*cap; otherwise cap later
      dnum_ff[0] <= {req_water_stored, 30'd0};
      dcap_ff[0] <= req_storage_limit;
      drem_ff[0] <= '0;
      dq_ff[0]   <= '0;
   end

   // the top 32 numerator bits (61..30), the stored value, seed the first
   // stage; with a nonzero capacity, a quotient of 2^31 or more raises an overflow flag
   logic dovf_ff [0:D0];
   always_ff @(posedge clock) begin
      dovf_ff[0] <= ({2'b0, req_water_stored} >= {1'b0, req_storage_limit, 1'b0})
                    && (req_storage_limit != '0);
   end

   for (genvar g = 0; g < D0; g++) begin : g_div
      logic [VolW:0] rem_sh;
      logic [VolW:0] diff;
      logic          take;
      assign rem_sh = (g == 0) ? {1'b0, dnum_ff[g][QuoW-1:QuoW-VolW]}
                               : {drem_ff[g][VolW-1:0], dnum_ff[g][QuoW-1]};
      assign diff   = rem_sh - {1'b0, dcap_ff[g]};
      assign take   = (rem_sh >= {1'b0, dcap_ff[g]});
      always_ff @(posedge clock) begin
         if (reset) dv_ff[g+1] <= 1'b0;
         else       dv_ff[g+1] <= dv_ff[g];
         dsd_ff[g+1]  <= dsd_ff[g];
         dcap_ff[g+1] <= dcap_ff[g];
         dovf_ff[g+1] <= dovf_ff[g];
         dnum_ff[g+1] <= (g == 0) ? {dnum_ff[g][QuoW-VolW-1:0], {VolW{1'b0}}}
                                  : {dnum_ff[g][QuoW-2:0], 1'b0};
         drem_ff[g+1] <= take ? diff : rem_sh;
         dq_ff[g+1]   <= {dq_ff[g][SatW-2:0], take};
      end
   end

   // ---------------- saturation cap, leading-one position
   logic            s_v_ff;
   side_type        s_sd_ff;
   logic [SatW-1:0] s_ff;
   logic [SatW-1:0] s_cap;
   assign s_cap = (dovf_ff[D0] || dq_ff[D0] > OneQ30) ? OneQ30 : dq_ff[D0];

   always_ff @(posedge clock) begin
      if (reset) s_v_ff <= 1'b0;
      else       s_v_ff <= dv_ff[D0];
      s_sd_ff <= dsd_ff[D0];
      s_ff    <= s_cap;
   end

   // normalize: mantissa in Q1.30, shift count 30-top
   logic [4:0]  top;
   logic [30:0] mant0;
   always_comb begin
      top = '0;
      for (int i = 0; i <= 30; i++) begin
         if (s_ff[i]) top = 5'(i);
      end
      mant0 = s_ff << (5'd30 - top);
   end

   // ---------------- log squaring stages
   logic            lv_ff  [0:L0];
   side_type        lsd_ff [0:L0];
   logic [SatW-1:0] ls_ff  [0:L0];
   logic [31:0]     lm_ff  [0:L0];
   logic [4:0]      lsh_ff [0:L0];
   logic [LogFb-1:0] lf_ff [0:L0];

   always_ff @(posedge clock) begin
      if (reset) lv_ff[0] <= 1'b0;
      else       lv_ff[0] <= s_v_ff;
      lsd_ff[0] <= s_sd_ff;
      ls_ff[0]  <= s_ff;
      lm_ff[0]  <= {1'b0, mant0};
      lsh_ff[0] <= 5'd30 - top;
      lf_ff[0]  <= '0;
   end

   for (genvar g = 0; g < L0; g++) begin : g_log
      logic [63:0] sq;
      logic [33:0] m2;
      assign sq = lm_ff[g] * lm_ff[g];
      assign m2 = sq[63:30];
      always_ff @(posedge clock) begin
         if (reset) lv_ff[g+1] <= 1'b0;
         else       lv_ff[g+1] <= lv_ff[g];
         lsd_ff[g+1] <= lsd_ff[g];
         ls_ff[g+1]  <= ls_ff[g];
         lsh_ff[g+1] <= lsh_ff[g];
         lm_ff[g+1]  <= m2[31] ? 32'(m2 >> 1) : m2[31:0];
         lf_ff[g+1]  <= {lf_ff[g][LogFb-2:0], m2[31]};
      end
   end

   // ---------------- y = (expo * -log2 s) >> 16
   logic            yv_ff;
   side_type        ysd_ff;
   logic [SatW-1:0] ys_ff;
   logic [LogW-1:0] nlog;
   logic [44:0]     yprod;
   logic [28:0]     y_ff;
   assign nlog  = {lsh_ff[L0], {LogFb{1'b0}}} - LogW'(lf_ff[L0]);
   assign yprod = lsd_ff[L0].expo * nlog;

   always_ff @(posedge clock) begin
      if (reset) yv_ff <= 1'b0;
      else       yv_ff <= lv_ff[L0];
      ysd_ff <= lsd_ff[L0];
      ys_ff  <= ls_ff[L0];
      y_ff   <= yprod[44:16];
   end

   // ---------------- 2^-frac product stages
   logic            pv_ff  [0:LogFb];
   side_type        psd_ff [0:LogFb];
   logic [SatW-1:0] ps_ff  [0:LogFb];
   logic [28:0]     py_ff  [0:LogFb];
   logic [32:0]     pp_ff  [0:LogFb];

   always_ff @(posedge clock) begin
      if (reset) pv_ff[0] <= 1'b0;
      else       pv_ff[0] <= yv_ff;
      psd_ff[0] <= ysd_ff;
      ps_ff[0]  <= ys_ff;
      py_ff[0]  <= y_ff;
      pp_ff[0]  <= 33'h1_0000_0000;
   end

   for (genvar g = 0; g < LogFb; g++) begin : g_pow
      localparam logic [32:0] CStep = exp_const(g + 1);
      logic [65:0] pr;
      assign pr = pp_ff[g] * CStep;
      always_ff @(posedge clock) begin
         if (reset) pv_ff[g+1] <= 1'b0;
         else       pv_ff[g+1] <= pv_ff[g];
         psd_ff[g+1] <= psd_ff[g];
         ps_ff[g+1]  <= ps_ff[g];
         py_ff[g+1]  <= py_ff[g];
         pp_ff[g+1]  <= py_ff[g][LogFb-1-g] ? pr[64:32] : pp_ff[g];
      end
   end

   // ---------------- coefficient product and moisture product
   logic            cv_ff;
   side_type        csd_ff;
   logic [32:0]     cpow_ff;   // (coef*p)>>32, <= coef
   logic [8:0]      cq_ff;
   logic            cszero_ff;
   logic [47:0]     cbound_ff;
   logic [64:0]     cprod;
   logic [SatW-1:0] wilt30;
   logic [SatW-1:0] sdiff;
   logic [47:0]     bprod;
   assign cprod  = psd_ff[LogFb].coef * pp_ff[LogFb];
   assign wilt30 = SatW'({psd_ff[LogFb].wilt, 14'd0});
   assign sdiff  = ps_ff[LogFb] - wilt30;
   assign bprod  = (ps_ff[LogFb] > wilt30) ? sdiff * psd_ff[LogFb].por : '0;

   always_ff @(posedge clock) begin
      if (reset) cv_ff <= 1'b0;
      else       cv_ff <= pv_ff[LogFb];
      csd_ff    <= psd_ff[LogFb];
      cpow_ff   <= cprod[64:32];
      cq_ff     <= py_ff[LogFb][28:20];
      cszero_ff <= (ps_ff[LogFb] == '0);
      cbound_ff <= bprod;
   end

   // ---------------- shift, select, output register
   logic [32:0] power;
   logic [25:0] bound;
   logic        lim;
   logic [32:0] rate;
   always_comb begin
      if (csd_ff.expo == '0)      power = {1'b0, csd_ff.coef};
      else if (cszero_ff)         power = '0;
      else if (cq_ff >= 9'd64)    power = '0;
      else                        power = cpow_ff >> cq_ff[5:0];
      bound = cbound_ff[47:22];
      lim   = (33'(bound) < power);
      rate  = lim ? 33'(bound) : power;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else       rsp_strobe <= cv_ff;
      rsp_exfiltration_rate <= csd_ff.nocap ? '0 : (rate[32] ? '1 : rate[31:0]);
      rsp_no_capacity       <= csd_ff.nocap;
      rsp_moisture_limited  <= csd_ff.nocap ? 1'b0 : lim;
   end

endmodule

### tb/exfil_checker.sv
`timescale 1ns / 1ps

// watches the cell, floor and result channels, predicts each result word
// and compares it with what the kernel returns
module exfil_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_start,
   input  logic                        req_busy,
   input  logic [ser_pkg::VolW-1:0]    req_water_stored,
   input  logic [ser_pkg::VolW-1:0]    req_storage_limit,
   input  logic [ser_pkg::FracW-1:0]   req_wilting_fraction,
   input  logic [ser_pkg::FracW-1:0]   req_mean_porosity,
   input  logic [ser_pkg::VolW-1:0]    req_rate_coefficient,
   input  logic [ser_pkg::ExpW-1:0]    req_saturation_exponent,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [ser_pkg::FloorW-1:0]  csr_capacity_floor,
   input  logic                        rsp_strobe,
   input  logic [ser_pkg::VolW-1:0]    rsp_exfiltration_rate,
   input  logic                        rsp_no_capacity,
   input  logic                        rsp_moisture_limited,
   output int                          fail_count,
   output int                          pending_count,
   output int                          limited_seen,
   output int                          empty_seen
);
   import ser_pkg::*;

   typedef struct packed {
      logic [VolW-1:0] rate;
      logic            no_cap;
      logic            limited;
   } exfil_word_type;

   exfil_word_type  expected_rates[$];
   logic [63:0]     root_step[1:LogFb];
   logic [FloorW-1:0] floor_q;

   // integer square root on 64 bits
   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // -log2 of a Q1.30 saturation, Q.20
   function automatic logic [63:0] neg_log2(input logic [63:0] s);
      int          top;
      logic [63:0] m, frac;
      top = 0;
      frac = 0;
      for (int i = 0; i <= 30; i++) if (s[i]) top = i;
      m = s << (30 - top);
      for (int i = 0; i < LogFb; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(30 - top) << LogFb) - frac;
   endfunction

   // coefficient scaled by 2^-y, y in Q.20
   function automatic logic [63:0] scale_pow2(input logic [63:0] coef, input logic [63:0] y);
      logic [63:0] q, p, prod;
      q = y >> LogFb;
      p = 64'd1 << 32;
      for (int i = 1; i <= LogFb; i++)
         if (y[LogFb-i]) begin
            prod = p * root_step[i];
            p = prod >> 32;
         end
      if (q >= 64) return 0;
      prod = coef * p;
      return (prod >> 32) >> q;
   endfunction

   function automatic exfil_word_type predict_rate(
      input logic [63:0] stored, cap, wilt, por, coef, expo);
      exfil_word_type w;
      logic [63:0] s, power, bound, wilt30;
      if (cap <= 64'(floor_q)) begin
         w.rate = 0;
         w.no_cap = 1;
         w.limited = 0;
         return w;
      end
      s = (stored << 30) / cap;
      if (s > (64'd1 << 30)) s = 64'd1 << 30;
      if (expo == 0) power = coef;
      else if (s == 0) power = 0;
      else power = scale_pow2(coef, (expo * neg_log2(s)) >> 16);
      wilt30 = wilt << 14;
      bound = (s > wilt30) ? (((s - wilt30) * por) >> 22) : 64'd0;
      w.no_cap = 0;
      w.limited = bound < power;
      if (w.limited) power = bound;
      w.rate = (power > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : power[31:0];
      return w;
   endfunction

   // square-root ladder of 2^-(2^-i) constants
   initial begin
      logic [63:0] c;
      c = 64'd1 << 31;
      for (int i = 1; i <= LogFb; i++) begin
         c = int_sqrt(c << 32);
         root_step[i] = c;
      end
   end

   initial begin
      fail_count = 0;
      limited_seen = 0;
      empty_seen = 0;
   end

   assign pending_count = expected_rates.size();

   // predict on accepted cells, compare on result words
   always @(posedge clock) begin
      exfil_word_type w;
      if (reset) begin
         floor_q <= '0;
      end else begin
         if (csr_valid && csr_ready) floor_q <= csr_capacity_floor;
         if (req_start && !req_busy)
            expected_rates.push_back(predict_rate(64'(req_water_stored),
               64'(req_storage_limit), 64'(req_wilting_fraction),
               64'(req_mean_porosity), 64'(req_rate_coefficient),
               64'(req_saturation_exponent)));
         if (rsp_strobe) begin
            if (expected_rates.size() == 0) begin
               $error("unexpected result word, rate %h", rsp_exfiltration_rate);
               fail_count++;
            end else begin
               w = expected_rates.pop_front();
               if (w.limited) limited_seen++;
               if (w.no_cap) empty_seen++;
               if (rsp_exfiltration_rate !== w.rate) begin
                  $error("exfiltration_rate expected %h actual %h", w.rate,
                         rsp_exfiltration_rate);
                  fail_count++;
               end
               if (rsp_no_capacity !== w.no_cap) begin
                  $error("no_capacity expected %b actual %b", w.no_cap, rsp_no_capacity);
                  fail_count++;
               end
               if (rsp_moisture_limited !== w.limited) begin
                  $error("moisture_limited expected %b actual %b", w.limited,
                         rsp_moisture_limited);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import ser_pkg::*;

   localparam int StallLimit = 4000;
   localparam int DrainCycles = 120;

   logic                clock;
   logic                reset;
   logic                req_start;
   logic                req_busy;
   logic [VolW-1:0]     req_water_stored;
   logic [VolW-1:0]     req_storage_limit;
   logic [FracW-1:0]    req_wilting_fraction;
   logic [FracW-1:0]    req_mean_porosity;
   logic [VolW-1:0]     req_rate_coefficient;
   logic [ExpW-1:0]     req_saturation_exponent;
   logic                csr_valid;
   logic                csr_ready;
   logic [FloorW-1:0]   csr_capacity_floor;
   logic                rsp_strobe;
   logic [VolW-1:0]     rsp_exfiltration_rate;
   logic                rsp_no_capacity;
   logic                rsp_moisture_limited;
   int                  fail_count, pending_count, limited_seen, empty_seen;
   int                  quiet_cycles;
   int                  cells_sent;
   bit                  no_idle;

   soil_exfiltration_rate_top u_top (.*);

   exfil_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog on cycles with no accepted word on any channel
   always @(posedge clock) begin
      if (reset || (req_start && !req_busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_cell(input logic [31:0] stored, cap, input logic [16:0] wilt, por,
                            input logic [31:0] coef, input logic [19:0] expo);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_water_stored <= stored;
      req_storage_limit <= cap;
      req_wilting_fraction <= wilt;
      req_mean_porosity <= por;
      req_rate_coefficient <= coef;
      req_saturation_exponent <= expo;
      req_start <= 1'b1;
      @(posedge clock);
      while (req_busy) @(posedge clock);
      cells_sent++;
   endtask

   // floor writes only once the pipeline is empty
   task automatic write_floor(input logic [15:0] value);
      req_start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_capacity_floor <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [16:0] rand_fraction();
      case ($urandom_range(0, 5))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic random_cell(input logic [15:0] floor_v);
      logic [31:0] cap, stored, coef;
      logic [19:0] expo;
      case ($urandom_range(0, 7))
         0: cap = 32'($urandom_range(0, floor_v));
         1: cap = 32'(floor_v) + 32'($urandom_range(1, 4));
         2: cap = 32'($urandom_range(1, 1 << 20));
         default: cap = $urandom | 32'h0001_0000;
      endcase
      case ($urandom_range(0, 5))
         0: stored = 0;
         1: stored = cap;
         2: stored = $urandom;
         3: stored = cap >> $urandom_range(1, 31);
         default: stored = 32'((64'(cap) * $urandom_range(0, 1023)) >> 10);
      endcase
      case ($urandom_range(0, 5))
         0: coef = 0;
         1: coef = 32'hFFFF_FFFF;
         default: coef = $urandom;
      endcase
      case ($urandom_range(0, 5))
         0: expo = 0;
         1: expo = 20'($urandom);
         default: expo = 20'($urandom_range(1, 6 << 16));
      endcase
      send_cell(stored, cap, rand_fraction(), rand_fraction(), coef, expo);
   endtask

   initial begin
      logic [15:0] floors[4];
      reset = 1'b1;
      req_start = 1'b0;
      req_water_stored = '0;
      req_storage_limit = '0;
      req_wilting_fraction = '0;
      req_mean_porosity = '0;
      req_rate_coefficient = '0;
      req_saturation_exponent = '0;
      csr_valid = 1'b0;
      csr_capacity_floor = '0;
      cells_sent = 0;
      no_idle = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed corners at the reset floor
      send_cell(32'd0, 32'd0, 17'd0, 17'd0, 32'h0100_0000, 20'd0);
      send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0, 17'd65536, 32'hFFFF_FFFF, 20'hFFFFF);
      send_cell(32'd0, 32'h0100_0000, 17'd0, 17'd65536, 32'h0100_0000, 20'd0);
      send_cell(32'd0, 32'h0100_0000, 17'd0, 17'd65536, 32'h0100_0000, 20'h10000);
      send_cell(32'h0080_0000, 32'h0100_0000, 17'd65536, 17'd65536, 32'h0100_0000, 20'h10000);
      send_cell(32'h0080_0000, 32'h0100_0000, 17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 20'h20000);
      send_cell(32'hFFFF_FFFF, 32'd1, 17'd0, 17'h1FFFF, 32'hFFFF_FFFF, 20'd1);
      send_cell(32'd1, 32'hFFFF_FFFF, 17'd0, 17'h1FFFF, 32'hFFFF_FFFF, 20'd1);
      send_cell(32'd1, 32'hFFFF_FFFF, 17'd0, 17'h1FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
      send_cell(32'h00C0_0000, 32'h0100_0000, 17'd16384, 17'd32768, 32'h0010_0000, 20'h08000);
      send_cell(32'h0100_0000, 32'h0100_0000, 17'd0, 17'd0, 32'd0, 20'h10000);
      send_cell(32'h5555_5555, 32'hAAAA_AAAA, 17'h0AAAA, 17'h15555, 32'h5555_5555, 20'h55555);
      send_cell(32'hAAAA_AAAA, 32'h5555_5555, 17'h15555, 17'h0AAAA, 32'hAAAA_AAAA, 20'hAAAAA);

      floors[0] = 16'hFFFF;
      floors[1] = 16'($urandom);
      floors[2] = 16'($urandom_range(1, 64));
      floors[3] = 16'h0000;
      foreach (floors[k]) begin
         write_floor(floors[k]);
         send_cell(32'h0100_0000, 32'(floors[k]), 17'd0, 17'd65536, 32'h0100_0000, 20'd0);
         send_cell(32'h0100_0000, 32'(floors[k]) + 1, 17'd0, 17'd65536, 32'h0100_0000,
                   20'd0);
         for (int n = 0; n < 300; n++) begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
            random_cell(floors[k]);
         end
         no_idle = 0;
      end
      req_start <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d cells over five floor settings", cells_sent);
      $display("moisture-bound results %0d, below-floor results %0d", limited_seen, empty_seen);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
rtl/ser_pkg.sv
rtl/soil_exfiltration_rate_top.sv
tb/exfil_checker.sv
tb/tb.sv
